[src/qvr_pkg.sv]
`timescale 1ns / 1ps

package qvr_pkg;

    localparam int COORD_BITS = 24;
    localparam int QUAT_BITS  = 16;
    localparam int PROD_BITS  = 2 * QUAT_BITS;
    localparam int MAT_BITS   = PROD_BITS + 2;
    localparam int LEN_BITS   = PROD_BITS + 1;
    localparam int MUL_BITS   = MAT_BITS + COORD_BITS;
    localparam int ACC_BITS   = MUL_BITS + 2;
    localparam int HI_BITS    = ACC_BITS - COORD_BITS;
    localparam int REM_BITS   = LEN_BITS;
    localparam int ADDR_BITS  = 4;
    localparam int DATA_BITS  = 32;

    typedef enum logic [1:0] {
        REG_ROT_W = 2'd0,
        REG_ROT_X = 2'd1,
        REG_ROT_Y = 2'd2,
        REG_ROT_Z = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic signed [COORD_BITS-1:0] point_z;
    } point_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] rotated_x;
        logic signed [COORD_BITS-1:0] rotated_y;
        logic signed [COORD_BITS-1:0] rotated_z;
        logic                         saturated;
        logic                         zero_quat_error;
    } result_t;

    // rotation matrix scaled by |q|^2, row major
    typedef struct packed {
        logic [8:0][MAT_BITS-1:0] m;
        logic [LEN_BITS-1:0]      len2;
        logic                     zero;
    } rot_t;

    // one restoring division step state, three lanes
    typedef struct packed {
        logic [2:0]                 neg;
        logic [2:0]                 ovf;
        logic [2:0][REM_BITS-1:0]   rem;
        logic [2:0][COORD_BITS-1:0] lowq;
    } dstage_t;

endpackage

[src/qvr_regs.sv]
`timescale 1ns / 1ps

module qvr_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [qvr_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [qvr_pkg::DATA_BITS-1:0]  pwdata,
    output logic [qvr_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready,
    output qvr_pkg::rot_t                  rot
);

    logic signed [qvr_pkg::QUAT_BITS-1:0] rot_w_reg, rot_x_reg, rot_y_reg, rot_z_reg;
    logic signed [qvr_pkg::PROD_BITS-1:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [qvr_pkg::PROD_BITS-1:0] xy_reg, wz_reg, xz_reg, wy_reg, yz_reg, wx_reg;
    qvr_pkg::rot_t rot_reg, rot_next;
    qvr_pkg::reg_idx_t idx;
    logic wr_en;
    logic signed [qvr_pkg::QUAT_BITS-1:0] rd_val;

    assign idx    = qvr_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_w_reg <= qvr_pkg::QUAT_BITS'(16384);
            rot_x_reg <= '0;
            rot_y_reg <= '0;
            rot_z_reg <= '0;
        end else if (wr_en) begin
            unique case (idx)
                qvr_pkg::REG_ROT_W: rot_w_reg <= pwdata[qvr_pkg::QUAT_BITS-1:0];
                qvr_pkg::REG_ROT_X: rot_x_reg <= pwdata[qvr_pkg::QUAT_BITS-1:0];
                qvr_pkg::REG_ROT_Y: rot_y_reg <= pwdata[qvr_pkg::QUAT_BITS-1:0];
                qvr_pkg::REG_ROT_Z: rot_z_reg <= pwdata[qvr_pkg::QUAT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            qvr_pkg::REG_ROT_W: rd_val = rot_w_reg;
            qvr_pkg::REG_ROT_X: rd_val = rot_x_reg;
            qvr_pkg::REG_ROT_Y: rd_val = rot_y_reg;
            qvr_pkg::REG_ROT_Z: rd_val = rot_z_reg;
            default:            rd_val = '0;
        endcase
        prdata = qvr_pkg::DATA_BITS'(rd_val);
    end

    // products of the quaternion components
    always_ff @(posedge aclk) begin
        ww_reg <= rot_w_reg * rot_w_reg;
        xx_reg <= rot_x_reg * rot_x_reg;
        yy_reg <= rot_y_reg * rot_y_reg;
        zz_reg <= rot_z_reg * rot_z_reg;
        xy_reg <= rot_x_reg * rot_y_reg;
        wz_reg <= rot_w_reg * rot_z_reg;
        xz_reg <= rot_x_reg * rot_z_reg;
        wy_reg <= rot_w_reg * rot_y_reg;
        yz_reg <= rot_y_reg * rot_z_reg;
        wx_reg <= rot_w_reg * rot_x_reg;
    end

    always_comb begin
        logic signed [qvr_pkg::MAT_BITS-1:0] e_ww, e_xx, e_yy, e_zz;
        logic signed [qvr_pkg::MAT_BITS-1:0] e_xy, e_wz, e_xz, e_wy, e_yz, e_wx;
        e_ww = qvr_pkg::MAT_BITS'(ww_reg);
        e_xx = qvr_pkg::MAT_BITS'(xx_reg);
        e_yy = qvr_pkg::MAT_BITS'(yy_reg);
        e_zz = qvr_pkg::MAT_BITS'(zz_reg);
        e_xy = qvr_pkg::MAT_BITS'(xy_reg);
        e_wz = qvr_pkg::MAT_BITS'(wz_reg);
        e_xz = qvr_pkg::MAT_BITS'(xz_reg);
        e_wy = qvr_pkg::MAT_BITS'(wy_reg);
        e_yz = qvr_pkg::MAT_BITS'(yz_reg);
        e_wx = qvr_pkg::MAT_BITS'(wx_reg);
        rot_next.m[0] = e_ww + e_xx - e_yy - e_zz;
        rot_next.m[1] = (e_xy - e_wz) <<< 1;
        rot_next.m[2] = (e_xz + e_wy) <<< 1;
        rot_next.m[3] = (e_xy + e_wz) <<< 1;
        rot_next.m[4] = e_ww - e_xx + e_yy - e_zz;
        rot_next.m[5] = (e_yz - e_wx) <<< 1;
        rot_next.m[6] = (e_xz - e_wy) <<< 1;
        rot_next.m[7] = (e_yz + e_wx) <<< 1;
        rot_next.m[8] = e_ww - e_xx - e_yy + e_zz;
        rot_next.len2 = qvr_pkg::LEN_BITS'($unsigned(ww_reg))
                      + qvr_pkg::LEN_BITS'($unsigned(xx_reg))
                      + qvr_pkg::LEN_BITS'($unsigned(yy_reg))
                      + qvr_pkg::LEN_BITS'($unsigned(zz_reg));
        rot_next.zero = (ww_reg == '0) && (xx_reg == '0) && (yy_reg == '0)
                     && (zz_reg == '0);
    end

    always_ff @(posedge aclk) begin
        rot_reg <= rot_next;
    end

    assign rot = rot_reg;

endmodule

[src/qvr_front.sv]
`timescale 1ns / 1ps

module qvr_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             take,
    input  qvr_pkg::point_t  pt_in,
    input  qvr_pkg::rot_t    rot,
    output logic             out_valid,
    output qvr_pkg::dstage_t out_st
);

    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic signed [qvr_pkg::COORD_BITS-1:0] pt0_reg [3];
    logic signed [qvr_pkg::COORD_BITS-1:0] pt1_reg [3];
    logic signed [qvr_pkg::MUL_BITS-1:0]   mul2_reg [9];
    logic signed [qvr_pkg::ACC_BITS-1:0]   acc3_reg [3];
    logic [2:0]                            neg4_reg;
    logic [qvr_pkg::ACC_BITS-1:0]          mag4_reg [3];
    qvr_pkg::dstage_t                      st5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= take;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pt0_reg[0] <= pt_in.point_x;
            pt0_reg[1] <= pt_in.point_y;
            pt0_reg[2] <= pt_in.point_z;
            pt1_reg    <= pt0_reg;
            for (int i = 0; i < 9; i++) begin
                mul2_reg[i] <= $signed(rot.m[i]) * pt1_reg[i % 3];
            end
            for (int r = 0; r < 3; r++) begin
                acc3_reg[r] <= qvr_pkg::ACC_BITS'(mul2_reg[3*r])
                             + qvr_pkg::ACC_BITS'(mul2_reg[3*r+1])
                             + qvr_pkg::ACC_BITS'(mul2_reg[3*r+2]);
                neg4_reg[r] <= acc3_reg[r][qvr_pkg::ACC_BITS-1];
                mag4_reg[r] <= acc3_reg[r][qvr_pkg::ACC_BITS-1] ? -acc3_reg[r]
                                                                 : acc3_reg[r];
                st5_reg.neg[r]  <= neg4_reg[r];
                st5_reg.ovf[r]  <= mag4_reg[r][qvr_pkg::ACC_BITS-1:qvr_pkg::COORD_BITS]
                                   >= qvr_pkg::HI_BITS'(rot.len2);
                st5_reg.rem[r]  <= mag4_reg[r][qvr_pkg::COORD_BITS +: qvr_pkg::REM_BITS];
                st5_reg.lowq[r] <= mag4_reg[r][qvr_pkg::COORD_BITS-1:0];
            end
        end
    end

    assign out_valid = v5_reg;
    assign out_st    = st5_reg;

endmodule

[src/qvr_div.sv]
`timescale 1ns / 1ps

module qvr_div (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  qvr_pkg::dstage_t in_st,
    input  qvr_pkg::rot_t    rot,
    output logic             out_valid,
    output qvr_pkg::result_t out_res
);

    localparam int CB = qvr_pkg::COORD_BITS;

    function automatic qvr_pkg::dstage_t div_step(input qvr_pkg::dstage_t a,
                                                  input logic [qvr_pkg::LEN_BITS-1:0] d);
        qvr_pkg::dstage_t         b;
        logic [qvr_pkg::REM_BITS:0] t;
        logic                       ge;
        b = a;
        for (int l = 0; l < 3; l++) begin
            t  = {a.rem[l], a.lowq[l][CB-1]};
            ge = t >= {1'b0, d};
            b.rem[l]  = ge ? qvr_pkg::REM_BITS'(t - {1'b0, d}) : qvr_pkg::REM_BITS'(t);
            b.lowq[l] = {a.lowq[l][CB-2:0], ge};
        end
        return b;
    endfunction

    logic [CB-1:0]    v_reg;
    qvr_pkg::dstage_t st_reg [CB];

    for (genvar k = 0; k < CB; k++) begin : g_step
        if (k == 0) begin : g_first
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[k] <= 1'b0;
                end else if (en) begin
                    v_reg[k] <= in_valid;
                end
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    st_reg[k] <= div_step(in_st, rot.len2);
                end
            end
        end else begin : g_next
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[k] <= 1'b0;
                end else if (en) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    st_reg[k] <= div_step(st_reg[k-1], rot.len2);
                end
            end
        end
    end

    logic             fin_v_reg;
    qvr_pkg::result_t fin_reg, fin_next;

    always_comb begin
        qvr_pkg::dstage_t             s;
        logic [CB-1:0]                q;
        logic [CB-1:0]                mag;
        logic [CB-1:0]                val [3];
        logic [2:0]                   over;
        s = st_reg[CB-1];
        for (int l = 0; l < 3; l++) begin
            q = s.lowq[l];
            over[l] = s.ovf[l] || (s.neg[l] ? (q[CB-1] && (q[CB-2:0] != '0)) : q[CB-1]);
            if (over[l]) begin
                mag = s.neg[l] ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
            end else begin
                mag = q;
            end
            val[l] = s.neg[l] ? -mag : mag;
        end
        if (rot.zero) begin
            fin_next = '0;
            fin_next.zero_quat_error = 1'b1;
        end else begin
            fin_next.rotated_x       = val[0];
            fin_next.rotated_y       = val[1];
            fin_next.rotated_z       = val[2];
            fin_next.saturated       = |over;
            fin_next.zero_quat_error = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_v_reg <= 1'b0;
        end else if (en) begin
            fin_v_reg <= v_reg[CB-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fin_reg <= fin_next;
        end
    end

    assign out_valid = fin_v_reg;
    assign out_res   = fin_reg;

endmodule

[src/quaternion_vector_rotate.sv]
`timescale 1ns / 1ps
// channel   direction  payload            handshake
// s_        in         qvr_pkg::point_t   s_valid / s_ready
// m_        out        qvr_pkg::result_t  m_valid / m_ready
// apb       in         rot_w..rot_z       psel / penable / pwrite, pready tied high
//
// one point per cycle sustained while the skid register is empty; an output stall that fills it holds input off
// the divider is 24 restoring stages, one quotient bit each
// reset holds s_ready low; a new quaternion reaches the matrix through the product and matrix registers
// on an output stall a skid register catches the last result and freezes the pipeline

module quaternion_vector_rotate (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  qvr_pkg::point_t                s_payload,
    output logic                           m_valid,
    input  logic                           m_ready,
    output qvr_pkg::result_t               m_payload,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [qvr_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [qvr_pkg::DATA_BITS-1:0]  pwdata,
    output logic [qvr_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready
);

    qvr_pkg::rot_t    rot;
    logic             en;
    logic             take;
    logic             front_v;
    qvr_pkg::dstage_t front_st;
    logic             div_v;
    qvr_pkg::result_t div_res;
    logic             run_reg;
    logic             m_valid_reg, skid_valid_reg;
    qvr_pkg::result_t m_data_reg, skid_data_reg;
    logic             push, pop;

    assign en      = !skid_valid_reg;
    assign s_ready = en && run_reg;
    assign take    = s_valid && s_ready;

    qvr_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .rot     (rot)
    );

    qvr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .take      (take),
        .pt_in     (s_payload),
        .rot       (rot),
        .out_valid (front_v),
        .out_st    (front_st)
    );

    qvr_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (front_v),
        .in_st     (front_st),
        .rot       (rot),
        .out_valid (div_v),
        .out_res   (div_res)
    );

    assign push = en && div_v;
    assign pop  = m_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            run_reg <= 1'b1;
            if (!m_valid_reg || pop) begin
                if (skid_valid_reg) begin
                    m_valid_reg    <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    m_valid_reg <= push;
                end
            end else if (push) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || pop) begin
            if (skid_valid_reg) begin
                m_data_reg <= skid_data_reg;
            end else if (push) begin
                m_data_reg <= div_res;
            end
        end else if (push) begin
            skid_data_reg <= div_res;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_data_reg;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid holds a transfer while output is empty");

    a_skid_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> !s_ready)
        else $error("input taken while skid is full");

    a_zero_quat_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.zero_quat_error) |->
            (m_payload.rotated_x == '0 && m_payload.rotated_y == '0 &&
             m_payload.rotated_z == '0 && !m_payload.saturated))
        else $error("zero quaternion result not cleared");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && !s_ready))
        else $error("handshake active right after reset");

endmodule

[tb/qvr_checker.sv]
`timescale 1ns / 1ps

module qvr_checker (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  qvr_pkg::point_t  s_payload,
    input  logic             m_valid,
    input  logic             m_ready,
    input  qvr_pkg::result_t m_payload,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic             pready,
    input  logic [qvr_pkg::ADDR_BITS-1:0] paddr,
    input  logic [qvr_pkg::DATA_BITS-1:0] pwdata,
    output int               errors,
    output int               pending
);
    import qvr_pkg::*;

    logic signed [15:0] quat [4];
    result_t rotated_q[$];

    function automatic logic signed [COORD_BITS-1:0] div_clamp(
        input logic signed [127:0] num, input logic signed [127:0] len2,
        inout logic sat);
        logic signed [127:0] q;
        logic signed [127:0] hi;
        logic signed [127:0] lo;
        hi = (128'sd1 <<< (COORD_BITS - 1)) - 1;
        lo = -(128'sd1 <<< (COORD_BITS - 1));
        q = num / len2;
        if (q > hi) begin
            sat = 1'b1;
            q = hi;
        end else if (q < lo) begin
            sat = 1'b1;
            q = lo;
        end
        return q[COORD_BITS-1:0];
    endfunction

    function automatic result_t rotate_point(input point_t p);
        logic signed [127:0] w, x, y, z, len2, px, py, pz;
        logic signed [127:0] m [9];
        result_t r;
        logic sat;
        w = quat[REG_ROT_W]; x = quat[REG_ROT_X];
        y = quat[REG_ROT_Y]; z = quat[REG_ROT_Z];
        px = p.point_x; py = p.point_y; pz = p.point_z;
        len2 = w*w + x*x + y*y + z*z;
        r = '0;
        if (len2 == 0) begin
            r.zero_quat_error = 1'b1;
            return r;
        end
        m[0] = w*w + x*x - y*y - z*z;
        m[1] = 2 * (x*y - w*z);
        m[2] = 2 * (x*z + w*y);
        m[3] = 2 * (x*y + w*z);
        m[4] = w*w - x*x + y*y - z*z;
        m[5] = 2 * (y*z - w*x);
        m[6] = 2 * (x*z - w*y);
        m[7] = 2 * (y*z + w*x);
        m[8] = w*w - x*x - y*y + z*z;
        sat = 1'b0;
        r.rotated_x = div_clamp(m[0]*px + m[1]*py + m[2]*pz, len2, sat);
        r.rotated_y = div_clamp(m[3]*px + m[4]*py + m[5]*pz, len2, sat);
        r.rotated_z = div_clamp(m[6]*px + m[7]*py + m[8]*pz, len2, sat);
        r.saturated = sat;
        return r;
    endfunction

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            quat[REG_ROT_W] <= 16'sd16384;
            quat[REG_ROT_X] <= '0;
            quat[REG_ROT_Y] <= '0;
            quat[REG_ROT_Z] <= '0;
            errors <= 0;
        end else begin
            if (psel && penable && pwrite && pready)
                quat[paddr[ADDR_BITS-1:2]] <= pwdata[15:0];
            if (s_valid && s_ready)
                rotated_q.push_back(rotate_point(s_payload));
            if (m_valid && m_ready) begin
                if (rotated_q.size() == 0) begin
                    $display("%0t: unexpected transfer, actual %h", $time, m_payload);
                    errors <= errors + 1;
                end else begin
                    want = rotated_q.pop_front();
                    if (want !== m_payload) begin
                        $display("%0t: mismatch expected x=%0d y=%0d z=%0d s=%b e=%b",
                            $time, want.rotated_x, want.rotated_y, want.rotated_z,
                            want.saturated, want.zero_quat_error);
                        $display("%0t:          actual   x=%0d y=%0d z=%0d s=%b e=%b",
                            $time, m_payload.rotated_x, m_payload.rotated_y,
                            m_payload.rotated_z, m_payload.saturated,
                            m_payload.zero_quat_error);
                        errors <= errors + 1;
                    end
                end
            end
        end
        pending = rotated_q.size();
    end

endmodule

[tb/quaternion_vector_rotate_tb.sv]
`timescale 1ns / 1ps

module quaternion_vector_rotate_tb;
    import qvr_pkg::*;

    localparam int WATCHDOG = 20000;
    localparam int LATENCY  = 31;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    point_t s_payload = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    result_t m_payload;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [DATA_BITS-1:0] pwdata = '0;
    logic [DATA_BITS-1:0] prdata;
    logic pready;
    int errors, pending;
    int idle_cycles = 0;
    bit quiet = 1'b0;
    bit hold_sink = 1'b0;

    always #2 aclk = ~aclk;

    quaternion_vector_rotate u_top (.*);

    qvr_checker u_checker (.*);

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: random stalls, long hold when asked
    always @(negedge aclk) begin
        if (hold_sink)
            m_ready <= 1'b0;
        else if (!quiet && $urandom_range(0, 3) == 0)
            m_ready <= 1'b0;
        else
            m_ready <= 1'b1;
    end

    task automatic reg_write(input reg_idx_t idx, input logic [15:0] value);
        @(negedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= ADDR_BITS'(idx) << 2;
        pwdata <= {{16{value[15]}}, value};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic set_quat(input logic [15:0] w, x, y, z);
        reg_write(REG_ROT_W, w);
        reg_write(REG_ROT_X, x);
        reg_write(REG_ROT_Y, y);
        reg_write(REG_ROT_Z, z);
        repeat (4) @(negedge aclk);
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
    endtask

    task automatic send_point(input point_t p, input bit gaps);
        int n;
        if (gaps && !quiet && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_payload <= p;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [COORD_BITS-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return {1'b0, {(COORD_BITS-1){1'b1}}};
            1: return {1'b1, {(COORD_BITS-1){1'b0}}};
            2: return COORD_BITS'($signed($urandom_range(0, 2000)) - 1000);
            default: return COORD_BITS'($urandom);
        endcase
    endfunction

    function automatic point_t rand_point();
        point_t p;
        p.point_x = rand_coord();
        p.point_y = rand_coord();
        p.point_z = rand_coord();
        return p;
    endfunction

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [COORD_BITS-1:0] ext [4];
        int k;
        ext[0] = {1'b0, {(COORD_BITS-1){1'b1}}};
        ext[1] = {1'b1, {(COORD_BITS-1){1'b0}}};
        ext[2] = '0;
        ext[3] = '1;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // directed: identity at reset, then extreme points
        for (int i = 0; i < 4; i++)
            send_point('{ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4]}, 1'b0);
        drain();
        set_quat(16'h7fff, 16'h7fff, 16'h8000, 16'h7fff);
        for (int i = 0; i < 4; i++)
            send_point('{ext[i], ext[i], ext[(i + 3) % 4]}, 1'b0);
        send_point('{24'sd1, 24'sd0, 24'sd0}, 1'b0);
        drain();
        // zero quaternion
        set_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_point('{ext[0], ext[1], ext[3]}, 1'b0);
        send_point('{24'sd5, -24'sd7, 24'sd9}, 1'b0);
        drain();
        set_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        for (int i = 0; i < 4; i++)
            send_point('{ext[i], ext[(i + 2) % 4], ext[i]}, 1'b0);
        drain();
        // non-unit small quaternion, strong truncation
        set_quat(16'h0001, 16'h0000, 16'h0000, 16'h0001);
        send_point('{24'sd3, -24'sd3, 24'sd1}, 1'b0);
        send_point(rand_point(), 1'b0);
        drain();

        // random phases
        k = 0;
        while (k < 720) begin
            set_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
            if (k == 240) begin
                // long receiver hold while points keep coming
                fork
                    begin
                        hold_sink = 1'b1;
                        repeat (300) @(negedge aclk);
                        hold_sink = 1'b0;
                    end
                    for (int i = 0; i < 80; i++) send_point(rand_point(), 1'b0);
                join
                k += 80;
            end
            if (k >= 600) quiet = 1'b1;
            for (int i = 0; i < 60; i++) send_point(rand_point(), 1'b1);
            k += 60;
            drain();
        end

        drain();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
src/qvr_pkg.sv
src/qvr_regs.sv
src/qvr_front.sv
src/qvr_div.sv
src/quaternion_vector_rotate.sv
tb/qvr_checker.sv
tb/quaternion_vector_rotate_tb.sv
